### hw/rtl/ckf_pkg.sv
// ----------------------------------------------------------------------------
// ckf_pkg
// Shared types, constants and CRC-32C matrix helpers for the fingerprint core.
// ----------------------------------------------------------------------------
`default_nettype none

package ckf_pkg;

   localparam logic [31:0] CRC_POLY     = 32'h82F6_3B78;
   localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
   localparam int          MAX_BYTES    = 8;
   localparam int          CNT_W        = 4;

   // ZMAT[n][j] holds the input bits that feed output bit j after n zero bytes
   typedef logic [MAX_BYTES:0][31:0][31:0] zmat_type;
   typedef logic [31:0][31:0]              mat_type;

   // One queued transaction between the front and back parts
   typedef struct packed {
      logic             first;
      logic             last;
      logic [CNT_W-1:0] count;
      logic [31:0]      seed;
      logic [31:0]      dpart;
   } item_type;

   function automatic zmat_type build_zmat();
      zmat_type    m;
      logic [31:0] v;
      logic        lsb;
      m = '0;
      for (int n = 0; n <= MAX_BYTES; n++) begin
         for (int k = 0; k < 32; k++) begin
            v = 32'd1 << k;
            for (int s = 0; s < 8 * n; s++) begin
               lsb = v[0];
               v   = v >> 1;
               if (lsb) begin
                  v = v ^ CRC_POLY;
               end
            end
            for (int j = 0; j < 32; j++) begin
               m[n][j][k] = v[j];
            end
         end
      end
      return m;
   endfunction

   localparam zmat_type ZMAT = build_zmat();

   // Apply a GF(2) matrix: each output bit is an XOR tree over masked inputs
   function automatic logic [31:0] mat_apply(input mat_type m, input logic [31:0] c);
      logic [31:0] r;
      for (int j = 0; j < 32; j++) begin
         r[j] = ^(c & m[j]);
      end
      return r;
   endfunction

endpackage

`default_nettype wire

### hw/rtl/ckf_front.sv
// ----------------------------------------------------------------------------
// ckf_front
// Accepts request transactions, saturates the byte count and precomputes the
// state identifier seed and the data contribution of the word.
// ----------------------------------------------------------------------------
`default_nettype none

module ckf_front #(
   parameter int BYTES_PER_ITEM = 8
) (
   input  wire logic                      req_push,
   input  wire logic                      req_first,
   input  wire logic [31:0]               req_state_id,
   input  wire logic [63:0]               req_data_word,
   input  wire logic [ckf_pkg::CNT_W-1:0] req_byte_count,
   input  wire logic                      req_last,
   input  wire logic                      q_full,
   output logic                           q_write,
   output ckf_pkg::item_type              q_item
);

   localparam logic [ckf_pkg::CNT_W-1:0] CNT_MAX = ckf_pkg::CNT_W'(BYTES_PER_ITEM);

   logic [ckf_pkg::CNT_W-1:0] cnt_sat;
   logic [6:0]                pad_bits;
   logic [63:0]               padded;

   assign q_write  = req_push & ~q_full;
   assign cnt_sat  = (req_byte_count > CNT_MAX) ? CNT_MAX : req_byte_count;
   // Leading zero bytes do not change a CRC started from zero
   assign pad_bits = 7'd64 - {cnt_sat, 3'b000};
   assign padded   = req_data_word << pad_bits;

   always_comb begin
      q_item.first = req_first;
      q_item.last  = req_last;
      q_item.count = cnt_sat;
      q_item.seed  = req_first
                   ? ckf_pkg::mat_apply(ckf_pkg::ZMAT[4], ~req_state_id)
                   : '0;
      q_item.dpart = ckf_pkg::mat_apply(ckf_pkg::ZMAT[8], padded[31:0])
                   ^ ckf_pkg::mat_apply(ckf_pkg::ZMAT[4], padded[63:32]);
   end

endmodule

`default_nettype wire

### hw/rtl/ckf_queue.sv
// ----------------------------------------------------------------------------
// ckf_queue
// Small circular queue that decouples the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module ckf_queue #(
   parameter int DEPTH = 4
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  ckf_pkg::item_type      wr_item,
   input  wire logic              rd_en,
   output ckf_pkg::item_type      rd_item,
   output logic                   full,
   output logic                   empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   ckf_pkg::item_type entries_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              do_wr, do_rd;

   assign full    = (cnt_ff == FULL_CNT);
   assign empty   = (cnt_ff == '0);
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_item = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entries_ff[wr_ptr_ff] <= wr_item;
      end
   end

endmodule

`default_nettype wire

### hw/rtl/ckf_back.sv
// ----------------------------------------------------------------------------
// ckf_back
// Folds queued transactions into the running CRC and holds the fingerprint
// in an output register until it is popped.
// ----------------------------------------------------------------------------
`default_nettype none

module ckf_back (
   input  wire logic         clock,
   input  wire logic         reset,
   input  ckf_pkg::item_type q_item,
   input  wire logic         q_empty,
   output logic              q_read,
   input  wire logic         rsp_pop,
   output logic              rsp_empty,
   output logic [31:0]       rsp_fingerprint
);

   logic [31:0] crc_ff, crc_in;
   logic [31:0] fp_ff;
   logic        out_valid_ff, out_valid_in;
   logic        out_free;
   logic [31:0] base;
   logic [31:0] crc_next;

   assign out_free = ~out_valid_ff | rsp_pop;
   // Hold a closing transaction until the output register can take it
   assign q_read   = ~q_empty & (~q_item.last | out_free);
   assign base     = q_item.first ? q_item.seed : crc_ff;
   assign crc_next = ckf_pkg::mat_apply(ckf_pkg::ZMAT[q_item.count], base) ^ q_item.dpart;

   always_comb begin
      crc_in       = crc_ff;
      out_valid_in = out_valid_ff & ~rsp_pop;
      if (q_read) begin
         crc_in = q_item.last ? ckf_pkg::CRC_ALL_ONES : crc_next;
         if (q_item.last) begin
            out_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff       <= ckf_pkg::CRC_ALL_ONES;
         out_valid_ff <= 1'b0;
      end else begin
         crc_ff       <= crc_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_read && q_item.last) begin
         fp_ff <= ~crc_next;
      end
   end

   assign rsp_empty       = ~out_valid_ff;
   assign rsp_fingerprint = fp_ff;

endmodule

`default_nettype wire

### hw/rtl/crc32c_keyed_fingerprint_core.sv
// A fingerprint goes through the queue and the output register to the rsp_ ports.
// Throughput: one transaction per cycle unless the queue is full or a closing item
// waits on the output register; the back part's matrix update folds up to eight
// bytes per item into the running CRC. A four-entry queue between front and back
// absorbs short result stalls. Reset (synchronous, active high) empties the queue
// and output register and sets the running CRC to all ones.
// ----------------------------------------------------------------------------
// crc32c_keyed_fingerprint_core
// Keyed CRC-32C fingerprint engine with queue-style request and response ports.
// ----------------------------------------------------------------------------
`default_nettype none

module crc32c_keyed_fingerprint_core #(
   parameter int BYTES_PER_ITEM = 8,
   parameter int QUEUE_DEPTH    = 4
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_push,
   output logic                           req_full,
   input  wire logic                      req_first,
   input  wire logic [31:0]               req_state_id,
   input  wire logic [63:0]               req_data_word,
   input  wire logic [ckf_pkg::CNT_W-1:0] req_byte_count,
   input  wire logic                      req_last,
   output logic                           rsp_empty,
   input  wire logic                      rsp_pop,
   output logic [31:0]                    rsp_fingerprint
);

   ckf_pkg::item_type wr_item;
   ckf_pkg::item_type rd_item;
   logic              q_write;
   logic              q_read;
   logic              q_empty;

   ckf_front #(
      .BYTES_PER_ITEM (BYTES_PER_ITEM)
   ) u_front (
      .req_push       (req_push),
      .req_first      (req_first),
      .req_state_id   (req_state_id),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .q_full         (req_full),
      .q_write        (q_write),
      .q_item         (wr_item)
   );

   ckf_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_write),
      .wr_item (wr_item),
      .rd_en   (q_read),
      .rd_item (rd_item),
      .full    (req_full),
      .empty   (q_empty)
   );

   ckf_back u_back (
      .clock           (clock),
      .reset           (reset),
      .q_item          (rd_item),
      .q_empty         (q_empty),
      .q_read          (q_read),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_fingerprint (rsp_fingerprint)
   );

endmodule

`default_nettype wire

### hw/rtl/ckf_checker.sv
// ----------------------------------------------------------------------------
// ckf_checker
// Port-level checks for the fingerprint core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ckf_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_push,
   input wire logic        req_full,
   input wire logic        rsp_empty,
   input wire logic        rsp_pop,
   input wire logic [31:0] rsp_fingerprint
);

   // Nothing to deliver right after reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("response present after reset");

   // Queue has room right after reset
   a_room_after_reset: assert property (@(posedge clock)
      reset |=> !req_full)
      else $error("request side full after reset");

   a_rsp_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("response dropped without pop");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_fingerprint))
      else $error("fingerprint changed while waiting");

   // A full queue cannot appear without a push in the cycle before
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      (!req_full && !req_push) |=> !req_full)
      else $error("queue filled without a request transaction");

endmodule

bind crc32c_keyed_fingerprint_core ckf_checker u_ckf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_push        (req_push),
   .req_full        (req_full),
   .rsp_empty       (rsp_empty),
   .rsp_pop         (rsp_pop),
   .rsp_fingerprint (rsp_fingerprint)
);

`default_nettype wire
